>>> design/gaussian_population_encoder_top_macros.svh
// Assertion macros shared by the encoder's queue and sequencer modules
`ifndef GAUSSIAN_POPULATION_ENCODER_TOP_MACROS_SVH
`define GAUSSIAN_POPULATION_ENCODER_TOP_MACROS_SVH

// Condition must never hold outside reset
`define GPE_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle
`define GPE_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle
`define GPE_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/gpe_pkg.sv
// Shared types, constants and the exponent table of the population encoder
`timescale 1ns / 1ps

package gpe_pkg;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 36;

   localparam logic [CSR_AW-1:0] REG_PROB_BOUNDS  = 3'd0;
   localparam logic [CSR_AW-1:0] REG_DIR_BOUNDS   = 3'd1;
   localparam logic [CSR_AW-1:0] REG_DIST_BOUNDS  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_CLASS_BOUNDS = 3'd3;
   localparam logic [CSR_AW-1:0] REG_NEURON_COUNT = 3'd4;
   localparam logic [CSR_AW-1:0] REG_PEAK_CURRENT = 3'd5;
   localparam logic [CSR_AW-1:0] REG_BASE_CURRENT = 3'd6;
   localparam logic [CSR_AW-1:0] REG_SPREAD       = 3'd7;

   // Register reset values
   localparam logic [35:0] RST_PROB_BOUNDS  = 36'd17179924890;
   localparam logic [35:0] RST_DIR_BOUNDS   = 36'd17179869184;
   localparam logic [35:0] RST_DIST_BOUNDS  = 36'd8589946388;
   localparam logic [15:0] RST_CLASS_BOUNDS = 16'd1542;
   localparam logic [4:0]  RST_NEURON_COUNT = 5'd2;
   localparam logic [14:0] RST_PEAK_CURRENT = 15'd10240;
   localparam logic [15:0] RST_BASE_CURRENT = 16'd0;
   localparam logic [15:0] RST_SPREAD       = 16'd1024;

   // Stream widths
   localparam int IN_TDATA_W  = 64;
   localparam int OUT_TDATA_W = 24;
   localparam int VAL_W       = 18;
   localparam int CLASS_LSB   = 54;

   // Datapath widths
   localparam int D_W      = 34;  // spread * |span|
   localparam int NUM_W    = 24;  // signed distance numerator
   localparam int N_W      = 53;  // dividend mag * 2^28 + d/2
   localparam int Q_W      = 19;  // quotient bits below 8.0 in Q.16
   localparam int U_W      = 21;  // x*x/2 in Q.16
   localparam int R_W      = 31;  // Q1.30 product
   localparam int G_W      = 17;  // Gaussian in Q.16, up to 1.0
   localparam int TAB_W    = 30;

   typedef struct packed {
      logic signed [18:0] vmc;   // min - value
      logic signed [18:0] span;  // max - min
      logic [D_W-1:0]     d;
   } lane_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic [5:0] idx;
      logic       frc;  // gaussian is forced, no division
      logic       one;  // forced value is 1.0 (else 0)
   } ctl_type;

   typedef struct packed {
      ctl_type    ctl;
      lane_type   lane;
      logic [3:0] j;
      logic [3:0] nm1;
   } issue_type;

   // Q0.30 factors exp(-2^(b-16)), one per bit of u
   function automatic logic [TAB_W-1:0] exp_coef(input logic [4:0] b);
      logic [TAB_W-1:0] c;
      unique case (b)
         5'd0:  c = 30'd1073725440;
         5'd1:  c = 30'd1073709056;
         5'd2:  c = 30'd1073676290;
         5'd3:  c = 30'd1073610760;
         5'd4:  c = 30'd1073479712;
         5'd5:  c = 30'd1073217664;
         5'd6:  c = 30'd1072693760;
         5'd7:  c = 30'd1071646719;
         5'd8:  c = 30'd1069555701;
         5'd9:  c = 30'd1065385899;
         5'd10: c = 30'd1057095000;
         5'd11: c = 30'd1040706261;
         5'd12: c = 30'd1008687096;
         5'd13: c = 30'd947573834;
         5'd14: c = 30'd836230973;
         5'd15: c = 30'd651257337;
         5'd16: c = 30'd395007542;
         5'd17: c = 30'd145315154;
         5'd18: c = 30'd19666268;
         5'd19: c = 30'd360200;
         5'd20: c = 30'd121;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> design/gpe_fifo.sv
// Two-entry event queue between the front and the back of the encoder
`timescale 1ns / 1ps
`include "gaussian_population_encoder_top_macros.svh"

module gpe_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  logic [WIDTH-1:0] din_i,
   output logic             full_o,
   input  logic             pop_i,
   output logic             valid_o,
   output logic [WIDTH-1:0] dout_o
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full_o  = (count_ff == 2'd2);
   assign valid_o = (count_ff != 2'd0);
   assign dout_o  = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_i;
      rd_ptr_in = rd_ptr_ff ^ pop_i;
      count_in  = count_ff + 2'(push_i) - 2'(pop_i);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= din_i;
      end
   end

   `GPE_NEVER(a_fifo_overflow, clock, reset, push_i && (count_ff == 2'd2), "push into full queue")
   `GPE_NEVER(a_fifo_underflow, clock, reset, pop_i && (count_ff == 2'd0), "pop from empty queue")
   `GPE_NEXT(a_fifo_fill, clock, reset, push_i && !pop_i, count_ff != 2'd0, "push lost")

endmodule

>>> design/gpe_front.sv
// Front end: accepts events, clamps scalars and classifies fields for the queue
`timescale 1ns / 1ps

module gpe_front #(
   parameter int FIELD_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [gpe_pkg::IN_TDATA_W-1:0]    req_tdata,
   input  logic [2:0][35:0]                  bounds_i,
   input  logic [15:0]                       class_bounds_i,
   input  logic [15:0]                       spread_i,
   output logic                              push_o,
   input  logic                              full_i,
   output logic [FIELD_COUNT-1:0]            mask_o,
   output logic [8:0]                        lit_o,
   output gpe_pkg::lane_type [FIELD_COUNT-2:0] lanes_o
);

   localparam int SC = FIELD_COUNT - 1;

   logic                    s1_v_ff, s1_v_in;
   logic [61:0]             s1_data_ff;
   logic                    s2_v_ff, s2_v_in;
   logic signed [18:0]      s2_vmc_ff [SC];
   logic signed [18:0]      s2_span_ff [SC];
   logic [17:0]             s2_aspan_ff [SC];
   logic [FIELD_COUNT-1:0]  s2_mask_ff;
   logic [8:0]              s2_lit_ff;

   logic signed [17:0]      v_w [SC];
   logic signed [17:0]      lo_w [SC];
   logic signed [17:0]      hi_w [SC];
   logic signed [17:0]      vc_w [SC];
   logic signed [18:0]      vmc_w [SC];
   logic signed [18:0]      span_w [SC];
   logic signed [18:0]      nspan_w [SC];
   logic [17:0]             aspan_w [SC];
   logic [FIELD_COUNT-1:0]  mask_w;
   logic [7:0]              cls_w;
   logic [8:0]              lit_w;
   logic                    s2_free;
   logic                    s1_move;

   // Handshake between the two stages and the queue
   assign push_o     = s2_v_ff && (s2_mask_ff != '0) && !full_i;
   assign s2_free    = !s2_v_ff || (s2_mask_ff == '0) || !full_i;
   assign s1_move    = s1_v_ff && s2_free;
   assign req_tready = !s1_v_ff || s2_free;

   // Clamp each scalar, form its offsets and mark the fields to encode
   always_comb begin
      for (int f = 0; f < SC; f++) begin
         v_w[f]  = signed'(s1_data_ff[f*gpe_pkg::VAL_W +: gpe_pkg::VAL_W]);
         lo_w[f] = signed'(bounds_i[f][17:0]);
         hi_w[f] = signed'(bounds_i[f][35:18]);
         if (v_w[f] > hi_w[f]) begin
            vc_w[f] = hi_w[f];
         end else if (v_w[f] < lo_w[f]) begin
            vc_w[f] = lo_w[f];
         end else begin
            vc_w[f] = v_w[f];
         end
         vmc_w[f]   = 19'(lo_w[f]) - 19'(vc_w[f]);
         span_w[f]  = 19'(hi_w[f]) - 19'(lo_w[f]);
         nspan_w[f] = -span_w[f];
         aspan_w[f] = span_w[f][18] ? nspan_w[f][17:0] : span_w[f][17:0];
         mask_w[f]  = (v_w[f] != '0);
      end
      mask_w[FIELD_COUNT-1] = (cls_w != 8'd0);
   end

   // Position of the class within its bounds, plus one; zero when out of range
   always_comb begin
      cls_w = s1_data_ff[gpe_pkg::CLASS_LSB +: 8];
      if ((cls_w < class_bounds_i[7:0]) || (cls_w > class_bounds_i[15:8])) begin
         lit_w = 9'd0;
      end else begin
         lit_w = {1'b0, cls_w} - {1'b0, class_bounds_i[7:0]} + 9'd1;
      end
   end

   // Queue payload: width d is formed on the way in
   always_comb begin
      for (int f = 0; f < SC; f++) begin
         lanes_o[f].vmc  = s2_vmc_ff[f];
         lanes_o[f].span = s2_span_ff[f];
         lanes_o[f].d    = gpe_pkg::D_W'(spread_i) * gpe_pkg::D_W'(s2_aspan_ff[f]);
      end
   end
   assign mask_o = s2_mask_ff;
   assign lit_o  = s2_lit_ff;

   // Stage valid flags
   always_comb begin
      s1_v_in = s1_v_ff;
      s2_v_in = s2_v_ff;
      if (req_tvalid && req_tready) begin
         s1_v_in = 1'b1;
      end else if (s1_move) begin
         s1_v_in = 1'b0;
      end
      if (s1_move) begin
         s2_v_in = 1'b1;
      end else if (s2_free) begin
         s2_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   // Capture the raw item
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata[61:0];
      end
   end

   // Capture the classified item
   always_ff @(posedge clock) begin
      if (s1_move) begin
         for (int f = 0; f < SC; f++) begin
            s2_vmc_ff[f]   <= vmc_w[f];
            s2_span_ff[f]  <= span_w[f];
            s2_aspan_ff[f] <= aspan_w[f];
         end
         s2_mask_ff <= mask_w;
         s2_lit_ff  <= lit_w;
      end
   end

endmodule

>>> design/gpe_seq.sv
// Back-end sequencer: walks encoded fields and neurons of the queued event
`timescale 1ns / 1ps
`include "gaussian_population_encoder_top_macros.svh"

module gpe_seq #(
   parameter int FIELD_COUNT = 4,
   parameter int MAX_NEURONS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid_i,
   input  logic [FIELD_COUNT-1:0]              mask_i,
   input  logic [8:0]                          lit_i,
   input  gpe_pkg::lane_type [FIELD_COUNT-2:0] lanes_i,
   output logic                                pop_o,
   input  logic [4:0]                          ncnt_i,
   input  logic                                adv_i,
   output gpe_pkg::issue_type                  issue_o
);

   localparam int FW = $clog2(FIELD_COUNT);
   localparam int NW = $clog2(MAX_NEURONS + 1);
   localparam int JW = $clog2(MAX_NEURONS);

   logic                    have_ff, have_in;
   logic [FIELD_COUNT-1:0]  rem_ff, rem_in;
   logic [JW-1:0]           j_ff, j_in;
   gpe_pkg::issue_type      issue_ff, issue_in;

   logic [NW-1:0]           n_eff;
   logic [JW-1:0]           nm1;
   logic [FW-1:0]           cur;
   logic [FIELD_COUNT-1:0]  cur_bit;
   logic [FIELD_COUNT-1:0]  rem_left;
   logic                    end_of_field;
   logic                    fire;
   logic                    last_c;
   logic                    is_class;
   gpe_pkg::lane_type       lane_sel;
   logic [6:0]              idx_w;

   assign issue_o = issue_ff;

   // Clamp the population height
   always_comb begin
      if (ncnt_i < 5'd2) begin
         n_eff = NW'(2);
      end else if (ncnt_i > 5'(MAX_NEURONS)) begin
         n_eff = NW'(MAX_NEURONS);
      end else begin
         n_eff = NW'(ncnt_i);
      end
      nm1 = JW'(n_eff - NW'(1));
   end

   // Pick the lowest field still to encode
   always_comb begin
      cur = '0;
      for (int i = FIELD_COUNT - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            cur = FW'(i);
         end
      end
      cur_bit  = FIELD_COUNT'(1) << cur;
      rem_left = rem_ff & ~cur_bit;
   end

   assign end_of_field = (j_ff == nm1);
   assign fire         = have_ff && adv_i;
   assign last_c       = end_of_field && (rem_left == '0);
   assign pop_o        = fire && last_c;
   assign is_class     = (cur == FW'(FIELD_COUNT - 1));

   // Build the next neuron item
   always_comb begin
      lane_sel = '0;
      for (int i = 0; i < FIELD_COUNT - 1; i++) begin
         if (cur == FW'(i)) begin
            lane_sel = lanes_i[i];
         end
      end
      idx_w = 7'(cur) * 7'(n_eff) + 7'(j_ff);
      issue_in.ctl.valid = fire;
      issue_in.ctl.last  = last_c;
      issue_in.ctl.idx   = idx_w[5:0];
      issue_in.ctl.frc   = is_class;
      issue_in.ctl.one   = is_class && (9'(j_ff) == lit_i);
      issue_in.lane      = is_class ? '0 : lane_sel;
      issue_in.j         = 4'(j_ff);
      issue_in.nm1       = 4'(nm1);
   end

   // Step through neurons, fields and events
   always_comb begin
      have_in = have_ff;
      rem_in  = rem_ff;
      j_in    = j_ff;
      if (fire) begin
         if (end_of_field) begin
            rem_in = rem_left;
            j_in   = '0;
            if (rem_left == '0) begin
               have_in = 1'b0;
            end
         end else begin
            j_in = j_ff + JW'(1);
         end
      end else if (!have_ff && head_valid_i) begin
         have_in = 1'b1;
         rem_in  = mask_i;
         j_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         rem_ff  <= '0;
         j_ff    <= '0;
      end else begin
         have_ff <= have_in;
         rem_ff  <= rem_in;
         j_ff    <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff.ctl.valid <= 1'b0;
      end else if (adv_i) begin
         issue_ff <= issue_in;
      end
   end

   `GPE_IMPLIES(a_seq_pop_last, clock, reset, pop_o, issue_in.ctl.last && issue_in.ctl.valid, "pop without last item")
   `GPE_NEVER(a_seq_empty_busy, clock, reset, have_ff && (rem_ff == '0), "busy with no field left")
   `GPE_NEVER(a_seq_pop_empty, clock, reset, pop_o && !head_valid_i, "pop with empty queue")

endmodule

>>> design/gpe_gauss.sv
// Back-end datapath: pipelined divider, exponent product and current scaling
`timescale 1ns / 1ps

module gpe_gauss (
   input  logic                              clock,
   input  logic                              reset,
   input  gpe_pkg::issue_type                issue_i,
   input  logic [14:0]                       peak_i,
   input  logic signed [15:0]                base_i,
   output logic                              adv_o,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gpe_pkg::OUT_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int DIV_STEPS = gpe_pkg::Q_W;
   localparam int EXP_STEPS = gpe_pkg::U_W;

   // Numerator stage
   gpe_pkg::ctl_type                 a_ctl_ff, a_ctl_in;
   logic signed [gpe_pkg::NUM_W-1:0] a_num_ff, a_num_in;
   logic [gpe_pkg::D_W-1:0]          a_d_ff;
   // Dividend stage
   gpe_pkg::ctl_type                 b_ctl_ff, b_ctl_in;
   logic [gpe_pkg::N_W-1:0]          b_n_ff, b_n_in;
   logic [gpe_pkg::D_W-1:0]          b_d_ff;
   // Divider stages, index 0 is the range check
   gpe_pkg::ctl_type                 div_ctl_ff [DIV_STEPS+1];
   gpe_pkg::ctl_type                 div_ctl_in [DIV_STEPS+1];
   logic [gpe_pkg::D_W-1:0]          div_r_ff [DIV_STEPS+1];
   logic [gpe_pkg::D_W-1:0]          div_r_in [DIV_STEPS+1];
   logic [gpe_pkg::D_W-1:0]          div_d_ff [DIV_STEPS+1];
   logic [gpe_pkg::D_W-1:0]          div_d_in [DIV_STEPS+1];
   logic [gpe_pkg::Q_W-1:0]          div_lo_ff [DIV_STEPS+1];
   logic [gpe_pkg::Q_W-1:0]          div_lo_in [DIV_STEPS+1];
   logic [gpe_pkg::Q_W-1:0]          div_q_ff [DIV_STEPS+1];
   logic [gpe_pkg::Q_W-1:0]          div_q_in [DIV_STEPS+1];
   // Exponent stages, index 0 is the square
   gpe_pkg::ctl_type                 exp_ctl_ff [EXP_STEPS+1];
   gpe_pkg::ctl_type                 exp_ctl_in [EXP_STEPS+1];
   logic [gpe_pkg::U_W-1:0]          exp_u_ff [EXP_STEPS+1];
   logic [gpe_pkg::U_W-1:0]          exp_u_in [EXP_STEPS+1];
   logic [gpe_pkg::R_W-1:0]          exp_r_ff [EXP_STEPS+1];
   logic [gpe_pkg::R_W-1:0]          exp_r_in [EXP_STEPS+1];
   // Rounding, scaling and output stages
   gpe_pkg::ctl_type                 g_ctl_ff;
   logic [gpe_pkg::G_W-1:0]          g_ff, g_in;
   gpe_pkg::ctl_type                 p_ctl_ff;
   logic [15:0]                      p_sc_ff, p_sc_in;
   gpe_pkg::ctl_type                 out_ctl_ff;
   logic [15:0]                      out_cur_ff, out_cur_in;

   logic signed [gpe_pkg::NUM_W-1:0] vmc_x, span_x, nm1_x, j_x;
   logic [gpe_pkg::NUM_W-1:0]        mag;
   logic [gpe_pkg::D_W:0]            div_t [DIV_STEPS];
   logic                             div_ge [DIV_STEPS];
   logic [37:0]                      sq;
   logic [61:0]                      exp_p [EXP_STEPS];
   logic [gpe_pkg::R_W-1:0]          rsum;
   logic [32:0]                      scaled;
   logic signed [17:0]               csum;

   // The whole back pipeline moves unless the result is held
   assign adv_o      = !out_ctl_ff.valid || rsp_tready;
   assign rsp_tvalid = out_ctl_ff.valid;
   assign rsp_tlast  = out_ctl_ff.last;
   assign rsp_tdata  = {2'b00, out_cur_ff, out_ctl_ff.idx};

   // Signed distance numerator
   always_comb begin
      vmc_x    = gpe_pkg::NUM_W'(issue_i.lane.vmc);
      span_x   = gpe_pkg::NUM_W'(issue_i.lane.span);
      nm1_x    = signed'({20'd0, issue_i.nm1});
      j_x      = signed'({20'd0, issue_i.j});
      a_num_in = vmc_x * nm1_x + j_x * span_x;
      a_ctl_in = issue_i.ctl;
   end

   // Dividend with rounding; zero width forces the result
   always_comb begin
      mag      = a_num_ff[gpe_pkg::NUM_W-1] ? gpe_pkg::NUM_W'(-a_num_ff) : a_num_ff;
      b_n_in   = gpe_pkg::N_W'({mag, 28'd0}) + gpe_pkg::N_W'(a_d_ff[gpe_pkg::D_W-1:1]);
      b_ctl_in = a_ctl_ff;
      if (!a_ctl_ff.frc && (a_d_ff == '0)) begin
         b_ctl_in.frc = 1'b1;
         b_ctl_in.one = (a_num_ff == '0);
      end
   end

   // Range check and restoring division, one quotient bit a stage
   always_comb begin
      div_ctl_in[0] = b_ctl_ff;
      if (!b_ctl_ff.frc && (b_n_ff[gpe_pkg::N_W-1:DIV_STEPS] >= b_d_ff)) begin
         div_ctl_in[0].frc = 1'b1;
         div_ctl_in[0].one = 1'b0;
      end
      div_r_in[0]  = b_n_ff[gpe_pkg::N_W-1:DIV_STEPS];
      div_d_in[0]  = b_d_ff;
      div_lo_in[0] = b_n_ff[DIV_STEPS-1:0];
      div_q_in[0]  = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         div_t[k]  = {div_r_ff[k], div_lo_ff[k][gpe_pkg::Q_W-1]};
         div_ge[k] = (div_t[k] >= {1'b0, div_d_ff[k]});
         div_r_in[k+1] = div_ge[k] ? gpe_pkg::D_W'(div_t[k] - {1'b0, div_d_ff[k]})
                                   : div_t[k][gpe_pkg::D_W-1:0];
         div_d_in[k+1]   = div_d_ff[k];
         div_lo_in[k+1]  = div_lo_ff[k] << 1;
         div_q_in[k+1]   = {div_q_ff[k][gpe_pkg::Q_W-2:0], div_ge[k]};
         div_ctl_in[k+1] = div_ctl_ff[k];
      end
   end

   // Square, then multiply in one factor per set bit of u
   always_comb begin
      sq = 38'(div_q_ff[DIV_STEPS]) * 38'(div_q_ff[DIV_STEPS]);
      exp_ctl_in[0] = div_ctl_ff[DIV_STEPS];
      exp_u_in[0]   = sq[37:17];
      exp_r_in[0]   = {1'b1, 30'd0};
      for (int b = 0; b < EXP_STEPS; b++) begin
         exp_p[b] = 62'(exp_r_ff[b]) * 62'(gpe_pkg::exp_coef(5'(b))) + 62'(2**29);
         exp_r_in[b+1]   = exp_u_ff[b][b] ? exp_p[b][60:30] : exp_r_ff[b];
         exp_u_in[b+1]   = exp_u_ff[b];
         exp_ctl_in[b+1] = exp_ctl_ff[b];
      end
   end

   // Round to Q.16, scale by the peak, add the base and saturate
   always_comb begin
      rsum = exp_r_ff[EXP_STEPS] + gpe_pkg::R_W'(8192);
      if (exp_ctl_ff[EXP_STEPS].frc) begin
         g_in = exp_ctl_ff[EXP_STEPS].one ? 17'h10000 : 17'h00000;
      end else begin
         g_in = rsum[30:14];
      end
      scaled  = 33'(peak_i) * 33'(g_ff) + 33'(32768);
      p_sc_in = scaled[31:16];
      csum    = 18'(base_i) + signed'({2'b00, p_sc_ff});
      if (csum > 18'sd32767) begin
         out_cur_in = 16'h7FFF;
      end else if (csum < -18'sd32768) begin
         out_cur_in = 16'h8000;
      end else begin
         out_cur_in = csum[15:0];
      end
   end

   // Stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff.valid   <= 1'b0;
         b_ctl_ff.valid   <= 1'b0;
         g_ctl_ff.valid   <= 1'b0;
         p_ctl_ff.valid   <= 1'b0;
         out_ctl_ff.valid <= 1'b0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_ctl_ff[k].valid <= 1'b0;
         end
         for (int b = 0; b <= EXP_STEPS; b++) begin
            exp_ctl_ff[b].valid <= 1'b0;
         end
      end else if (adv_o) begin
         a_ctl_ff   <= a_ctl_in;
         b_ctl_ff   <= b_ctl_in;
         g_ctl_ff   <= exp_ctl_ff[EXP_STEPS];
         p_ctl_ff   <= g_ctl_ff;
         out_ctl_ff <= p_ctl_ff;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_ctl_ff[k] <= div_ctl_in[k];
         end
         for (int b = 0; b <= EXP_STEPS; b++) begin
            exp_ctl_ff[b] <= exp_ctl_in[b];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv_o) begin
         a_num_ff   <= a_num_in;
         a_d_ff     <= issue_i.lane.d;
         b_n_ff     <= b_n_in;
         b_d_ff     <= a_d_ff;
         g_ff       <= g_in;
         p_sc_ff    <= p_sc_in;
         out_cur_ff <= out_cur_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            div_r_ff[k]  <= div_r_in[k];
            div_d_ff[k]  <= div_d_in[k];
            div_lo_ff[k] <= div_lo_in[k];
            div_q_ff[k]  <= div_q_in[k];
         end
         for (int b = 0; b <= EXP_STEPS; b++) begin
            exp_u_ff[b] <= exp_u_in[b];
            exp_r_ff[b] <= exp_r_in[b];
         end
      end
   end

endmodule

>>> design/gaussian_population_encoder_top.sv
// Top level of the Gaussian population encoder: registers, queue and back end
//
// Channel  Dir  Fields (lowest bit up)                                   Handshake
// req      in   tdata: probability, direction, distance, class_id, pad   tvalid/tready
// rsp      out  tdata: neuron_index, current, pad; tlast: last            tvalid/tready
// csr      in   csr_addr: register index, csr_wdata: value                 csr_we
//
// The back end issues one neuron per cycle unless the result is held; an event
// with k encoded fields of n neurons gives k*n results after a step that loads it.
// Events with no encoded field are dropped in the front end and give no result.
// The path from acceptance to the first result runs through the 19-stage divider
// and the 21-stage exponent multiplier chain.
// A stalled result freezes the whole back pipeline; the two-entry queue and
// the two front stages keep accepting events meanwhile. Reset is synchronous.
`timescale 1ns / 1ps

module gaussian_population_encoder_top #(
   parameter int MAX_NEURONS = 16,
   parameter int FIELD_COUNT = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // probability[17:0], direction[35:18], distance[53:36], class_id[61:54]
   input  logic [gpe_pkg::IN_TDATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // neuron_index[5:0], current[21:6]
   output logic [gpe_pkg::OUT_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [gpe_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [gpe_pkg::CSR_DW-1:0]        csr_wdata
);

   localparam int SC = FIELD_COUNT - 1;
   localparam int Q_WIDTH = FIELD_COUNT + 9 + SC * $bits(gpe_pkg::lane_type);

   logic [35:0]        prob_bounds_ff;
   logic [35:0]        dir_bounds_ff;
   logic [35:0]        dist_bounds_ff;
   logic [15:0]        class_bounds_ff;
   logic [4:0]         ncnt_ff;
   logic [14:0]        peak_ff;
   logic signed [15:0] base_ff;
   logic [15:0]        spread_ff;

   logic                            push;
   logic                            full;
   logic [FIELD_COUNT-1:0]          f_mask;
   logic [8:0]                      f_lit;
   gpe_pkg::lane_type [SC-1:0]      f_lanes;
   logic                            pop;
   logic                            q_valid;
   logic [Q_WIDTH-1:0]              q_dout;
   logic [FIELD_COUNT-1:0]          h_mask;
   logic [8:0]                      h_lit;
   gpe_pkg::lane_type [SC-1:0]      h_lanes;
   logic                            adv;
   gpe_pkg::issue_type              issue;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prob_bounds_ff  <= gpe_pkg::RST_PROB_BOUNDS;
         dir_bounds_ff   <= gpe_pkg::RST_DIR_BOUNDS;
         dist_bounds_ff  <= gpe_pkg::RST_DIST_BOUNDS;
         class_bounds_ff <= gpe_pkg::RST_CLASS_BOUNDS;
         ncnt_ff         <= gpe_pkg::RST_NEURON_COUNT;
         peak_ff         <= gpe_pkg::RST_PEAK_CURRENT;
         base_ff         <= gpe_pkg::RST_BASE_CURRENT;
         spread_ff       <= gpe_pkg::RST_SPREAD;
      end else if (csr_we) begin
         unique case (csr_addr)
            gpe_pkg::REG_PROB_BOUNDS:  prob_bounds_ff  <= csr_wdata;
            gpe_pkg::REG_DIR_BOUNDS:   dir_bounds_ff   <= csr_wdata;
            gpe_pkg::REG_DIST_BOUNDS:  dist_bounds_ff  <= csr_wdata;
            gpe_pkg::REG_CLASS_BOUNDS: class_bounds_ff <= csr_wdata[15:0];
            gpe_pkg::REG_NEURON_COUNT: ncnt_ff         <= csr_wdata[4:0];
            gpe_pkg::REG_PEAK_CURRENT: peak_ff         <= csr_wdata[14:0];
            gpe_pkg::REG_BASE_CURRENT: base_ff         <= signed'(csr_wdata[15:0]);
            gpe_pkg::REG_SPREAD:       spread_ff       <= csr_wdata[15:0];
         endcase
      end
   end

   // Accept and classify events
   gpe_front #(
      .FIELD_COUNT(FIELD_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .bounds_i       ({dist_bounds_ff, dir_bounds_ff, prob_bounds_ff}),
      .class_bounds_i (class_bounds_ff),
      .spread_i       (spread_ff),
      .push_o         (push),
      .full_i         (full),
      .mask_o         (f_mask),
      .lit_o          (f_lit),
      .lanes_o        (f_lanes)
   );

   // Queue classified events
   gpe_fifo #(
      .WIDTH(Q_WIDTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .din_i   ({f_mask, f_lit, f_lanes}),
      .full_o  (full),
      .pop_i   (pop),
      .valid_o (q_valid),
      .dout_o  (q_dout)
   );

   assign {h_mask, h_lit, h_lanes} = q_dout;

   // Walk fields and neurons
   gpe_seq #(
      .FIELD_COUNT(FIELD_COUNT),
      .MAX_NEURONS(MAX_NEURONS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .head_valid_i (q_valid),
      .mask_i       (h_mask),
      .lit_i        (h_lit),
      .lanes_i      (h_lanes),
      .pop_o        (pop),
      .ncnt_i       (ncnt_ff),
      .adv_i        (adv),
      .issue_o      (issue)
   );

   // Compute currents
   gpe_gauss u_gauss (
      .clock      (clock),
      .reset      (reset),
      .issue_i    (issue),
      .peak_i     (peak_ff),
      .base_i     (base_ff),
      .adv_o      (adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the Gaussian population encoder top level
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic [5:0]  idx;
      logic [15:0] cur;
      logic        last;
   } neuron_current_type;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [gpe_pkg::IN_TDATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [gpe_pkg::OUT_TDATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [gpe_pkg::CSR_AW-1:0] csr_addr = '0;
   logic [gpe_pkg::CSR_DW-1:0] csr_wdata = '0;

   // Shadow copy of the encoder registers
   logic [35:0]        bounds_q [3];
   logic [15:0]        class_bounds_q;
   logic [4:0]         count_q;
   logic [14:0]        peak_q;
   logic signed [15:0] base_q;
   logic [15:0]        spread_q;

   neuron_current_type pending_currents [$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatches = 0;
   int quiet_cycles = 0;

   longint unsigned exp_factor [21] = '{
      64'd1073725440, 64'd1073709056, 64'd1073676290, 64'd1073610760, 64'd1073479712,
      64'd1073217664, 64'd1072693760, 64'd1071646719, 64'd1069555701, 64'd1065385899,
      64'd1057095000, 64'd1040706261, 64'd1008687096, 64'd947573834, 64'd836230973,
      64'd651257337, 64'd395007542, 64'd145315154, 64'd19666268, 64'd360200, 64'd121};

   gaussian_population_encoder_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Gaussian weight in Q.16 for one neuron distance
   function automatic longint unsigned gauss_weight(input longint num,
                                                     input longint unsigned d);
      longint unsigned mag, x, u, r;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      if (d == 0) return (mag == 0) ? 64'd65536 : 64'd0;
      x = ((mag << 28) + d / 2) / d;
      if (x >= (64'd8 << 16)) return 64'd0;
      u = (x * x) >> 17;
      r = 64'd1 << 30;
      for (int b = 0; b < 21; b++)
         if (u[b]) r = (r * exp_factor[b] + (64'd1 << 29)) >> 30;
      return (r + (64'd1 << 13)) >> 14;
   endfunction

   function automatic logic [15:0] saturated_current(input longint unsigned scaled);
      longint c;
      c = longint'(base_q) + longint'(scaled);
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      return c[15:0];
   endfunction

   // Work out every neuron current one event produces
   task automatic predict_currents(input logic [17:0] vals [3], input logic [7:0] cls);
      neuron_current_type ev [$];
      neuron_current_type nc;
      longint n, v, lo, hi, span, num;
      longint unsigned d, g;
      logic signed [17:0] sv;
      int lit;
      logic [7:0] cmin, cmax;
      n = count_q;
      if (n < 2) n = 2;
      if (n > 16) n = 16;
      for (int f = 0; f < 3; f++) begin
         sv = vals[f];
         v = sv;
         sv = bounds_q[f][17:0];
         lo = sv;
         sv = bounds_q[f][35:18];
         hi = sv;
         if (v == 0) continue;
         if (v > hi) v = hi;
         else if (v < lo) v = lo;
         span = hi - lo;
         d = longint'(spread_q) * longint'(span < 0 ? -span : span);
         for (longint j = 0; j < n; j++) begin
            num = (lo - v) * (n - 1) + j * span;
            g = gauss_weight(num, d);
            nc.idx = 6'(f * n + j);
            nc.cur = saturated_current((longint'(peak_q) * g + 32768) >> 16);
            nc.last = 1'b0;
            ev.insert(ev.size(), nc);
         end
      end
      cmin = class_bounds_q[7:0];
      cmax = class_bounds_q[15:8];
      if (cls != 0) begin
         lit = (cls < cmin || cls > cmax) ? 0 : int'(cls) - int'(cmin) + 1;
         for (longint j = 0; j < n; j++) begin
            nc.idx = 6'(3 * n + j);
            nc.cur = saturated_current(j == lit ? longint'(peak_q) : 0);
            nc.last = 1'b0;
            ev.insert(ev.size(), nc);
         end
      end
      if (ev.size() > 0) ev[ev.size()-1].last = 1'b1;
      foreach (ev[i]) pending_currents.insert(pending_currents.size(), ev[i]);
   endtask

   // Send one event, idling at random first
   task automatic send_event(input logic [17:0] p, input logic [17:0] dr,
                             input logic [17:0] ds, input logic [7:0] cls);
      logic [17:0] vals [3];
      vals[0] = p;
      vals[1] = dr;
      vals[2] = ds;
      predict_currents(vals, cls);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b0, cls, ds, dr, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold until every expected current has come out and the pipe has emptied
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      wait (pending_currents.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register, then drop the write enable before returning
   task automatic write_reg(input logic [gpe_pkg::CSR_AW-1:0] idx, input logic [35:0] val);
      case (idx)
         gpe_pkg::REG_PROB_BOUNDS:  bounds_q[0] = val;
         gpe_pkg::REG_DIR_BOUNDS:   bounds_q[1] = val;
         gpe_pkg::REG_DIST_BOUNDS:  bounds_q[2] = val;
         gpe_pkg::REG_CLASS_BOUNDS: class_bounds_q = val[15:0];
         gpe_pkg::REG_NEURON_COUNT: count_q = val[4:0];
         gpe_pkg::REG_PEAK_CURRENT: peak_q = val[14:0];
         gpe_pkg::REG_BASE_CURRENT: base_q = val[15:0];
         default:                   spread_q = val[15:0];
      endcase
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [35:0] pack_bounds(input int lo, input int hi);
      logic [17:0] l, h;
      l = lo[17:0];
      h = hi[17:0];
      return {h, l};
   endfunction

   // Pick a fresh register setting, mostly ordered bounds
   task automatic randomize_config();
      int lo, hi;
      wait_quiet();
      for (int f = 0; f < 3; f++) begin
         if ($urandom_range(9) == 0) begin
            write_reg(gpe_pkg::CSR_AW'(f), 36'({$urandom(), $urandom()}));
         end else begin
            lo = $urandom_range(262143) - 131072;
            hi = lo + $urandom_range(131072);
            if (hi > 131071) hi = 131071;
            write_reg(gpe_pkg::CSR_AW'(f), pack_bounds(lo, hi));
         end
      end
      write_reg(gpe_pkg::REG_CLASS_BOUNDS, $urandom_range(1) ?
                {8'($urandom_range(255)), 8'($urandom_range(255))} :
                {8'($urandom_range(30) + 8), 8'($urandom_range(8))});
      write_reg(gpe_pkg::REG_NEURON_COUNT, $urandom_range(7) == 0 ? $urandom_range(31) :
                $urandom_range(3) == 0 ? 16 : $urandom_range(2, 6));
      write_reg(gpe_pkg::REG_PEAK_CURRENT, $urandom_range(32767));
      write_reg(gpe_pkg::REG_BASE_CURRENT, $urandom_range(65535));
      write_reg(gpe_pkg::REG_SPREAD, $urandom_range(15) == 0 ? 0 : $urandom_range(65535));
   endtask

   // Pick a scalar: zero, anywhere, or inside the field bounds
   function automatic logic [17:0] pick_scalar(input int f);
      logic signed [17:0] l, h;
      int lo, hi;
      l = bounds_q[f][17:0];
      h = bounds_q[f][35:18];
      lo = l;
      hi = h;
      case ($urandom_range(9))
         0: return 18'd0;
         1, 2: return 18'($urandom());
         default: begin
            if (hi < lo) return 18'($urandom());
            return 18'(lo + $urandom_range(hi - lo));
         end
      endcase
   endfunction

   // Check each current as it is accepted; watch for a stuck pipe
   always @(posedge clock) begin
      neuron_current_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_currents.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item idx=%0d cur=%0d last=%0b",
                           rsp_tdata[5:0], $signed(rsp_tdata[21:6]), rsp_tlast);
            end else begin
               want = pending_currents.pop_front();
               if (want.idx !== rsp_tdata[5:0] || want.cur !== rsp_tdata[21:6] ||
                   want.last !== rsp_tlast) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp idx=%0d cur=%0d last=%0b got idx=%0d cur=%0d last=%0b",
                              want.idx, $signed(want.cur), want.last, rsp_tdata[5:0],
                              $signed(rsp_tdata[21:6]), rsp_tlast);
               end
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Reset values: skips, empty event, clamping at both ends
   task automatic test_reset_values();
      bounds_q[0] = gpe_pkg::RST_PROB_BOUNDS;
      bounds_q[1] = gpe_pkg::RST_DIR_BOUNDS;
      bounds_q[2] = gpe_pkg::RST_DIST_BOUNDS;
      class_bounds_q = gpe_pkg::RST_CLASS_BOUNDS;
      count_q = gpe_pkg::RST_NEURON_COUNT;
      peak_q = gpe_pkg::RST_PEAK_CURRENT;
      base_q = gpe_pkg::RST_BASE_CURRENT;
      spread_q = gpe_pkg::RST_SPREAD;
      send_event(18'd0, 18'd0, 18'd0, 8'd0);
      send_event(18'h1FFFF, 18'h20000, 18'd1, 8'd6);
      send_event(18'h20000, 18'h1FFFF, 18'h3FFFF, 8'd255);
      send_event(18'd0, 18'd40000, 18'd0, 8'd0);
      send_event(18'd0, 18'd0, 18'd0, 8'd3);
   endtask

   // Register corners: zero span, zero spread, inverted bounds, class edges
   task automatic test_register_corners();
      wait_quiet();
      write_reg(gpe_pkg::REG_PROB_BOUNDS, pack_bounds(5000, 5000));
      write_reg(gpe_pkg::REG_DIR_BOUNDS, pack_bounds(60000, -60000));
      write_reg(gpe_pkg::REG_DIST_BOUNDS, pack_bounds(-131072, 131071));
      write_reg(gpe_pkg::REG_CLASS_BOUNDS, {8'd20, 8'd10});
      write_reg(gpe_pkg::REG_NEURON_COUNT, 5'd5);
      write_reg(gpe_pkg::REG_PEAK_CURRENT, 15'h7FFF);
      write_reg(gpe_pkg::REG_BASE_CURRENT, 16'h7FFF);
      write_reg(gpe_pkg::REG_SPREAD, 16'd0);
      send_event(18'd5000, 18'd1, 18'h20000, 8'd10);
      send_event(18'd7, 18'd60000, 18'h1FFFF, 8'd14);
      send_event(18'h3FFFF, 18'h3FFFF, 18'd3, 8'd15);
      send_event(18'd0, 18'd0, 18'd0, 8'd20);
      wait_quiet();
      write_reg(gpe_pkg::REG_SPREAD, 16'hFFFF);
      write_reg(gpe_pkg::REG_BASE_CURRENT, 16'h8000);
      write_reg(gpe_pkg::REG_PEAK_CURRENT, 15'd0);
      write_reg(gpe_pkg::REG_NEURON_COUNT, 5'd0);
      send_event(18'd4000, 18'd100, 18'd50, 8'd9);
      send_event(18'd6000, 18'h3FF00, 18'h2FFFF, 8'd21);
      wait_quiet();
      write_reg(gpe_pkg::REG_NEURON_COUNT, 5'd31);
      write_reg(gpe_pkg::REG_PEAK_CURRENT, 15'd20000);
      write_reg(gpe_pkg::REG_BASE_CURRENT, 16'hC000);
      write_reg(gpe_pkg::REG_SPREAD, 16'd1);
      write_reg(gpe_pkg::REG_CLASS_BOUNDS, {8'd255, 8'd0});
      send_event(18'd5000, 18'd30000, 18'd12345, 8'd1);
      send_event(18'd1, 18'd2, 18'd3, 8'd14);
      send_event(18'd0, 18'd0, 18'd99, 8'd255);
      wait_quiet();
      write_reg(gpe_pkg::REG_NEURON_COUNT, 5'd1);
      write_reg(gpe_pkg::REG_SPREAD, 16'd4096);
      write_reg(gpe_pkg::REG_BASE_CURRENT, 16'd0);
      send_event(18'd5000, 18'd0, 18'd0, 8'd1);
      send_event(18'd0, 18'd0, 18'd70000, 8'd2);
   endtask

   // Random events under changing registers and idling
   task automatic test_random_events(input int sender_pct, input int receiver_pct);
      logic [7:0] cls;
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      for (int i = 0; i < 90; i++) begin
         if (i % 30 == 0) randomize_config();
         case ($urandom_range(3))
            0: cls = 8'($urandom_range(255));
            1: cls = 8'd0;
            default: cls = class_bounds_q[7:0] + 8'($urandom_range(16));
         endcase
         send_event(pick_scalar(0), pick_scalar(1), pick_scalar(2), cls);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_register_corners();
      test_random_events(0, 0);
      test_random_events(63, 0);
      test_random_events(0, 63);
      test_random_events(11, 11);
      wait_quiet();
      if (mismatches == 0 && pending_currents.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
